/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the palette index builder sources.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* src/pib_pkg.sv */
// ----------------------------------------------------------------------------
// pib_pkg
// Types and constants shared by the palette index builder modules.
// ----------------------------------------------------------------------------
package pib_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int COLOUR_W         = 32;
    localparam int IDX_W            = 8;

    typedef struct packed {
        logic [COLOUR_W-1:0] pixel_colour;
        logic                first_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] colour_index;
        logic             is_new_colour;
        logic             overflow;
    } result_t;

    // What travels from cell to cell along the chain.
    typedef struct packed {
        logic                valid;
        logic [COLOUR_W-1:0] colour;
        logic                first;
        logic                found;
        logic                fresh;
        logic [IDX_W-1:0]    idx;
    } pib_token_t;

endpackage

/* src/pib_cell.sv */
// ----------------------------------------------------------------------------
// pib_cell
// One palette entry: compares the passing pixel, claims it on a match or
// takes its colour when empty, then hands the pixel to the next cell.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pib_cell
    import pib_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  pib_token_t tok_in,
    output pib_token_t tok_out
);

    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);

    logic [COLOUR_W-1:0] entry_reg;
    logic                entry_valid_reg;
    logic                entry_valid_next;
    pib_token_t          tok_reg;
    pib_token_t          tok_next;
    logic                hit;
    logic                empty;
    logic                write;

    // A first-pixel beat empties the entry before it is looked at.
    assign hit   = entry_valid_reg && !tok_in.first && (entry_reg == tok_in.colour);
    assign empty = !entry_valid_reg || tok_in.first;

    always_comb begin
        tok_next         = tok_in;
        entry_valid_next = entry_valid_reg;
        write            = 1'b0;
        if (tok_in.valid) begin
            if (tok_in.first) begin
                entry_valid_next = 1'b0;
            end
            if (!tok_in.found) begin
                if (hit) begin
                    tok_next.found = 1'b1;
                    tok_next.idx   = CELL_IDX;
                end else if (empty) begin
                    tok_next.found   = 1'b1;
                    tok_next.fresh   = 1'b1;
                    tok_next.idx     = CELL_IDX;
                    write            = 1'b1;
                    entry_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg         <= '0;
            entry_valid_reg <= 1'b0;
        end else if (advance) begin
            tok_reg         <= tok_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && write) begin
            entry_reg <= tok_in.colour;
        end
    end

    assign tok_out = tok_reg;

    `ASSERT_PROP(a_fill_from_beat, aclk, aresetn,
        (!entry_valid_reg ##1 entry_valid_reg) |-> $past(tok_in.valid && !tok_in.found && advance))
    `ASSERT_PROP(a_empty_claims, aclk, aresetn,
        (advance && tok_in.valid && !tok_in.found && empty) |=> (tok_reg.fresh && entry_valid_reg))

endmodule

/* src/pib_out.sv */
// ----------------------------------------------------------------------------
// pib_out
// Result register at the end of the chain, with the sticky overflow flag.
// ----------------------------------------------------------------------------
module pib_out
    import pib_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pib_token_t tok_in,
    output logic       advance,
    output result_t    m_result,
    output logic       m_valid,
    input  logic       m_ready
);

    result_t result_reg;
    result_t result_next;
    logic    valid_reg;
    logic    ovf_reg;
    logic    ovf_next;

    assign advance = !valid_reg || m_ready;

    // A pixel that leaves the chain unclaimed found every entry taken.
    always_comb begin
        ovf_next = (tok_in.first ? 1'b0 : ovf_reg) | !tok_in.found;
        result_next.colour_index  = tok_in.found ? tok_in.idx : '0;
        result_next.is_new_colour = tok_in.fresh;
        result_next.overflow      = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (advance) begin
            valid_reg <= tok_in.valid;
            if (tok_in.valid) begin
                ovf_reg <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tok_in.valid) begin
            result_reg <= result_next;
        end
    end

    assign m_result = result_reg;
    assign m_valid  = valid_reg;

endmodule

/* src/palette_index_builder.sv */
// ----------------------------------------------------------------------------
// palette_index_builder
// Assigns each 32-bit colour pixel its index in a first-seen colour palette.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel (valid/ready) and indices leave on the m_
// channel in the same order, one result beat per pixel beat.
// The palette lives in a chain of PALETTE_SIZE cells, one entry each. A pixel
// moves one cell per cycle while the chain advances, then through the output
// register; a new pixel may enter every cycle while s_ready is high. Pixels
// stay in order on the chain, so each sees every entry added by earlier ones.
// A pixel with first_pixel set empties each cell as it passes and clears the
// overflow flag when it reaches the output; it always becomes entry 0.
// Overflow is sticky per image: an unseen colour with the palette full gives
// index 0 and raises it.
// When m_ready is low with a result waiting, the whole chain holds and
// s_ready falls; nothing is lost. Reset empties every cell and clears the
// output valid and overflow flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_index_builder
    import pib_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  pixel_in_t s_pixel,
    input  logic      s_valid,
    output logic      s_ready,
    output result_t   m_result,
    output logic      m_valid,
    input  logic      m_ready
);

    pib_token_t tok [0:PALETTE_SIZE];
    logic       advance;

    assign s_ready = advance;

    always_comb begin
        tok[0]        = '0;
        tok[0].valid  = s_valid && advance;
        tok[0].colour = s_pixel.pixel_colour;
        tok[0].first  = s_pixel.first_pixel;
    end

    for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
        pib_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    pib_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tok_in   (tok[PALETTE_SIZE]),
        .advance  (advance),
        .m_result (m_result),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

    // A new entry can only be added while the palette still has room.
    `ASSERT_NEVER(a_new_not_overflow, aclk, aresetn,
        m_valid && m_result.is_new_colour && m_result.overflow)
    `ASSERT_PROP(a_first_is_entry0, aclk, aresetn,
        (advance && tok[1].valid && tok[1].first) |-> (tok[1].fresh && tok[1].idx == '0))

endmodule
